>>> rtl/assert_macros.svh
// assertion helpers for the rtl of this project
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// non-overlapping implication from ante to cons
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/hmmfwd_pkg.sv
// ----------------------------------------------------------------------------
// hmmfwd_pkg
// shared types and constants of the scaled forward step
// ----------------------------------------------------------------------------
`default_nettype none
package hmmfwd_pkg;
  localparam int unsigned DEF_MAX_STATES  = 16;
  localparam int unsigned DEF_MAX_SYMBOLS = 16;
  localparam int unsigned DEF_FRAC_BITS   = 16;
  localparam int unsigned WIDE_W          = 40;
  localparam int unsigned REG_W           = 5;

  typedef enum logic [1:0] {
    OP_LOAD_TRANS = 2'd0,
    OP_LOAD_EMIS  = 2'd1,
    OP_LOAD_INIT  = 2'd2,
    OP_OBSERVE    = 2'd3
  } op_t;

  typedef enum logic {
    REG_NUM_STATES  = 1'b0,
    REG_NUM_SYMBOLS = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ACC_RD,
    ST_ACC_MUL,
    ST_ACC_ADD,
    ST_EMIS_RD,
    ST_EMIS_MUL,
    ST_EMIS_ADD,
    ST_NORM_RD,
    ST_NORM_DIV,
    ST_NORM_RND,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

>>> rtl/hmmfwd_ram.sv
// ----------------------------------------------------------------------------
// hmmfwd_ram
// generic single-port-write ram with a registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module hmmfwd_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/hmm_scaled_forward_step_core.sv
// ----------------------------------------------------------------------------
// hmm_scaled_forward_step_core
// scaled forward step of a discrete hidden markov model, one shared mac
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one word per request: op, row/col index, probability,
//   symbol and a start-of-sequence flag. table loads (op 0..2) write the
//   transition, emission or initial table and give no output word.
//   an observe word (op 3) gives one m_axis word per state in use, state 0
//   first, with tlast on the final state; each holds the normalised alpha,
//   the unnormalised sum and a zero-sum flag.
// timing
//   a load writes its table in the load state and returns to idle. an observe
//   runs the mac pass (emission products alone at the start of a sequence),
//   then the normalising divider for each state; with a zero sum the divider
//   is skipped. s_axis tready is low meanwhile.
//   the rate is set by the single multiplier and single-bit restoring divider.
// reset
//   rst is synchronous; the configuration registers go to 16, tables are
//   undefined until loaded. the output register holds a word until m_axis
//   tready takes it, the sequencer waits for it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module hmm_scaled_forward_step_core #(
  parameter int unsigned MAX_STATES     = hmmfwd_pkg::DEF_MAX_STATES,
  parameter int unsigned MAX_SYMBOLS    = hmmfwd_pkg::DEF_MAX_SYMBOLS,
  parameter int unsigned PROB_FRAC_BITS = hmmfwd_pkg::DEF_FRAC_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // op[1:0], row_index[5:2], col_index[9:6], prob_value[26:10], symbol[30:27]
  input  wire logic [31:0] s_axis_tdata,
  // start_of_sequence
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // state_number[3:0], alpha_value[20:4], scale_sum[60:21], zero_sum[61]
  output logic [63:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [hmmfwd_pkg::REG_W-1:0] cfg_data
);
  import hmmfwd_pkg::*;

  localparam int unsigned SW   = $clog2(MAX_STATES);
  localparam int unsigned YW   = $clog2(MAX_SYMBOLS);
  localparam int unsigned F    = PROB_FRAC_BITS;
  localparam int unsigned PW   = F + 1;
  localparam int unsigned CW   = $clog2(F + 3);
  localparam logic [WIDE_W-1:0] WMAX = {WIDE_W{1'b1}};
  localparam logic [PW-1:0] PONE = PW'(1) << F;

  // field extraction
  op_t          in_op;
  logic [3:0]   in_row, in_col, in_sym;
  logic [16:0]  in_prob;
  assign in_op   = op_t'(s_axis_tdata[1:0]);
  assign in_row  = s_axis_tdata[5:2];
  assign in_col  = s_axis_tdata[9:6];
  assign in_prob = s_axis_tdata[26:10];
  assign in_sym  = s_axis_tdata[30:27];

  // configuration registers
  logic [REG_W-1:0] num_states, num_symbols;
  always_ff @(posedge clk) begin
    if (rst) begin
      num_states  <= REG_W'(16);
      num_symbols <= REG_W'(16);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_NUM_STATES:  num_states  <= cfg_data;
        REG_NUM_SYMBOLS: num_symbols <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [SW:0] n_eff;
  logic [YW:0] nsym_eff;
  always_comb begin
    if (num_states == '0) n_eff = (SW+1)'(1);
    else if (32'(num_states) > MAX_STATES) n_eff = (SW+1)'(MAX_STATES);
    else n_eff = (SW+1)'(num_states);
    if (num_symbols == '0) nsym_eff = (YW+1)'(1);
    else if (32'(num_symbols) > MAX_SYMBOLS) nsym_eff = (YW+1)'(MAX_SYMBOLS);
    else nsym_eff = (YW+1)'(num_symbols);
  end

  // latched request
  logic [PW-1:0] req_prob;
  logic [3:0]    req_row, req_col, req_sym;
  op_t           req_op;
  logic          req_start;

  // sequencer state
  state_t state, state_next;
  logic [SW:0] i_cnt, j_cnt;
  logic [CW-1:0] bit_cnt;
  logic [WIDE_W-1:0] acc, sum;
  logic [WIDE_W+F+1:0] prod;
  logic [WIDE_W:0] rem;
  logic [PW+1:0] quo;

  // saturated unnormalised value of the current state
  logic [WIDE_W-1:0] work_v;

  // memories
  logic             tr_we, em_we, in_we, pa_we, wa_we;
  logic [2*SW-1:0]  tr_wa, tr_ra;
  logic [SW+YW-1:0] em_wa, em_ra;
  logic [SW-1:0]    in_wa, in_ra, pa_wa, pa_ra, wa_wa, wa_ra;
  logic [PW-1:0]    tr_rd, em_rd, in_rd, pa_rd, pa_wd;
  logic [WIDE_W-1:0] wa_rd;

  hmmfwd_ram #(.WIDTH(PW), .DEPTH(MAX_STATES*MAX_STATES)) u_trans (
    .clk(clk), .we(tr_we), .waddr(tr_wa), .wdata(req_prob), .raddr(tr_ra), .rdata(tr_rd));
  hmmfwd_ram #(.WIDTH(PW), .DEPTH(MAX_STATES*MAX_SYMBOLS)) u_emis (
    .clk(clk), .we(em_we), .waddr(em_wa), .wdata(req_prob), .raddr(em_ra), .rdata(em_rd));
  hmmfwd_ram #(.WIDTH(PW), .DEPTH(MAX_STATES)) u_init (
    .clk(clk), .we(in_we), .waddr(in_wa), .wdata(req_prob), .raddr(in_ra), .rdata(in_rd));
  hmmfwd_ram #(.WIDTH(PW), .DEPTH(MAX_STATES)) u_prev (
    .clk(clk), .we(pa_we), .waddr(pa_wa), .wdata(pa_wd), .raddr(pa_ra), .rdata(pa_rd));
  hmmfwd_ram #(.WIDTH(WIDE_W), .DEPTH(MAX_STATES)) u_work (
    .clk(clk), .we(wa_we), .waddr(wa_wa), .wdata(work_v), .raddr(wa_ra), .rdata(wa_rd));

  logic [SW-1:0] i_idx, j_idx;
  assign i_idx = i_cnt[SW-1:0];
  assign j_idx = j_cnt[SW-1:0];
  logic sym_ok;
  assign sym_ok = ({1'b0, req_sym} < 5'(nsym_eff)) && (32'(req_sym) < MAX_SYMBOLS);

  // table write decode
  always_comb begin
    tr_we = (state == ST_LOAD) && (req_op == OP_LOAD_TRANS)
            && (32'(req_row) < MAX_STATES) && (32'(req_col) < MAX_STATES);
    em_we = (state == ST_LOAD) && (req_op == OP_LOAD_EMIS)
            && (32'(req_row) < MAX_STATES) && (32'(req_col) < MAX_SYMBOLS);
    in_we = (state == ST_LOAD) && (req_op == OP_LOAD_INIT)
            && (32'(req_col) < MAX_STATES);
    tr_wa = {SW'(req_row), SW'(req_col)};
    em_wa = {SW'(req_row), YW'(req_col)};
    in_wa = SW'(req_col);
    tr_ra = {i_idx, j_idx};
    em_ra = {j_idx, YW'(req_sym)};
    in_ra = j_idx;
    pa_ra = i_idx;
    wa_ra = j_idx;
    wa_wa = j_idx;
    pa_wa = j_idx;
  end

  // shared multiplier operands: one product per cycle
  logic [WIDE_W-1:0] mul_a;
  logic [PW-1:0]     mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_ACC_MUL:  begin mul_a = WIDE_W'(pa_rd); mul_b = tr_rd; end
      ST_EMIS_MUL: begin
        mul_a = req_start ? WIDE_W'(in_rd) : acc;
        mul_b = sym_ok ? em_rd : '0;
      end
      default: ;
    endcase
  end

  // divider step and rounding
  logic [WIDE_W:0] rem_sh;
  logic            div_ge;
  assign rem_sh = {rem[WIDE_W-1:0], 1'b0};
  assign div_ge = rem_sh >= {1'b0, sum};

  // last fraction step lands with the rnd state; final bit is pushed there
  logic [PW+1:0] quo_fin;
  assign quo_fin = {quo[PW:0], div_ge};

  logic [PW+1:0]   q_rnd;
  assign q_rnd  = (quo_fin + (PW+2)'(1)) >> 1;

  logic wa_v, pa_v;
  assign wa_we = wa_v;
  assign pa_we = pa_v;
  logic zero;
  assign zero = (sum == '0);

  // output register
  logic out_load;
  logic [3:0] out_state;
  logic [PW-1:0] out_alpha;
  logic [WIDE_W-1:0] out_sum;
  logic out_zero;
  logic out_last;

  always_comb begin
    state_next = state;
    wa_v = 1'b0;
    pa_v = 1'b0;
    pa_wd = '0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: if (s_axis_tvalid) begin
        state_next = (in_op == OP_OBSERVE)
                     ? (s_axis_tuser ? ST_EMIS_RD : ST_ACC_RD) : ST_LOAD;
      end
      ST_LOAD: state_next = ST_IDLE;
      ST_ACC_RD: state_next = ST_ACC_MUL;
      ST_ACC_MUL: state_next = ST_ACC_ADD;
      ST_ACC_ADD: state_next = (i_cnt + 1'b1 == n_eff) ? ST_EMIS_RD : ST_ACC_RD;
      ST_EMIS_RD: state_next = ST_EMIS_MUL;
      ST_EMIS_MUL: state_next = ST_EMIS_ADD;
      ST_EMIS_ADD: begin
        wa_v = 1'b1;
        if (j_cnt + 1'b1 == n_eff) state_next = ST_NORM_RD;
        else state_next = req_start ? ST_EMIS_RD : ST_ACC_RD;
      end
      ST_NORM_RD: state_next = zero ? ST_NORM_RND : ST_NORM_DIV;
      ST_NORM_DIV: if (32'(bit_cnt) == F) state_next = ST_NORM_RND;
      ST_NORM_RND: if (!m_axis_tvalid || m_axis_tready) begin
        pa_v = 1'b1;
        pa_wd = zero ? '0 : ((q_rnd > (PW+2)'(PONE)) ? PONE : PW'(q_rnd));
        out_load = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: state_next = (j_cnt + 1'b1 == n_eff) ? ST_IDLE : ST_NORM_RD;
      default: state_next = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // datapath registers
  logic [WIDE_W+F+1:0] prod_sh;
  assign prod_sh = req_start ? prod : (prod >> F);
  assign work_v  = (prod_sh > (WIDE_W+F+2)'(WMAX)) ? WMAX : WIDE_W'(prod_sh);
  always_ff @(posedge clk) begin
    prod <= (WIDE_W+F+2)'(mul_a) * (WIDE_W+F+2)'(mul_b);
    case (state)
      ST_IDLE: begin
        req_op <= in_op; req_row <= in_row; req_col <= in_col;
        req_sym <= in_sym; req_start <= s_axis_tuser;
        req_prob <= (in_prob > 17'(PONE)) ? PONE : PW'(in_prob);
        i_cnt <= '0; j_cnt <= '0; acc <= '0; sum <= '0;
      end
      ST_ACC_ADD: begin
        if ((WIDE_W+F+2)'(acc) + prod > (WIDE_W+F+2)'(WMAX)) acc <= WMAX;
        else acc <= WIDE_W'((WIDE_W+F+2)'(acc) + prod);
        i_cnt <= i_cnt + 1'b1;
      end
      ST_EMIS_ADD: begin
        acc <= work_v;
        if ((WIDE_W+1)'(sum) + (WIDE_W+1)'(work_v) > (WIDE_W+1)'(WMAX)) sum <= WMAX;
        else sum <= sum + work_v;
        if (j_cnt + 1'b1 == n_eff) j_cnt <= '0;
        else j_cnt <= j_cnt + 1'b1;
        i_cnt <= '0;
      end
      ST_EMIS_MUL: ;
      ST_NORM_RD: begin
        bit_cnt <= '0;
      end
      ST_NORM_DIV: begin
        if (bit_cnt == '0) begin
          // integer bit first, then F+1 fraction bits
          if ({1'b0, wa_rd} >= {1'b0, sum}) begin
            quo <= (PW+2)'(1); rem <= {1'b0, wa_rd - sum};
          end else begin
            quo <= '0; rem <= {1'b0, wa_rd};
          end
          bit_cnt <= bit_cnt + 1'b1;
        end else begin
          quo <= {quo[PW:0], div_ge};
          rem <= div_ge ? rem_sh - {1'b0, sum} : rem_sh;
          bit_cnt <= bit_cnt + 1'b1;
        end
      end
      ST_OUT: j_cnt <= j_cnt + 1'b1;
      default: ;
    endcase
    if (state == ST_ACC_RD && i_cnt == '0) acc <= '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (out_load) begin
      out_state <= 4'(j_cnt);
      out_alpha <= pa_wd;
      out_sum   <= sum;
      out_zero  <= zero;
      out_last  <= (j_cnt + 1'b1 == n_eff);
    end
  end

  assign m_axis_tdata = {2'b00, out_zero, out_sum, 17'(out_alpha), out_state};
  assign m_axis_tlast = out_last;

  `ASSERT_ALWAYS(a_ready_idle, clk, rst, !(s_axis_tready && state != ST_IDLE),
    "ready outside idle")
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
    "output word dropped")
  `ASSERT_ALWAYS(a_count, clk, rst, j_cnt <= n_eff, "state count overrun")
endmodule
`default_nettype wire
